// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the pid controller core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is high
`define PIDD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pid controller assertion failed");

// clocked check that also holds during reset
`define PIDD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pid controller assertion failed");

`else

`define PIDD_ASSERT(lbl, clk, rst, prop)
`define PIDD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hdl/pidd_pkg.sv -----
// ----------------------------------------------------------------------------
// pidd_pkg
// widths, register indexes, reset values and the configuration struct
// ----------------------------------------------------------------------------
package pidd_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int GAIN_W     = 18;
   localparam int LIM_W      = 15;
   localparam int DATA_W     = 16;
   localparam int ERR_W      = DATA_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int P_W        = GAIN_W + 1 + ERR_W;
   localparam int D_W        = GAIN_W + 1 + DIFF_W;
   localparam int ISUM_W     = P_W + 1;
   localparam int SUM_W      = D_W + 2;
   localparam int ACC_W      = LIM_W + FRAC_BITS + 1;
   localparam int CLIM_W     = LIM_W + FRAC_BITS + 1;
   localparam int IDX_W      = 3;
   localparam int CSR_DATA_W = GAIN_W;

   localparam logic [CLIM_W-1:0] TRUNC_BIAS = CLIM_W'((1 << FRAC_BITS) - 1);

   // register indexes
   localparam logic [IDX_W-1:0] REG_PROP_GAIN   = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_DEAD_BAND   = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_OUT_LIMIT   = IDX_W'(5);

   localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = GAIN_W'(1920);
   localparam logic [GAIN_W-1:0] RST_INTEG_GAIN  = GAIN_W'(51);
   localparam logic [GAIN_W-1:0] RST_DERIV_GAIN  = GAIN_W'(1587);
   localparam logic [LIM_W-1:0]  RST_DEAD_BAND   = LIM_W'(10);
   localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT = LIM_W'(9000);
   localparam logic [LIM_W-1:0]  RST_OUT_LIMIT   = LIM_W'(10000);

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [LIM_W-1:0]  dead_band;
      logic [LIM_W-1:0]  integ_limit;
      logic [LIM_W-1:0]  out_limit;
   } cfg_type;

endpackage

// ----- hdl/pidd_csr.sv -----
// ----------------------------------------------------------------------------
// pidd_csr
// gain, deadband and clamp registers behind the configuration write channel
// ----------------------------------------------------------------------------
module pidd_csr
   import pidd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_PROP_GAIN:   cfg_in.prop_gain   = wr_data[GAIN_W-1:0];
            REG_INTEG_GAIN:  cfg_in.integ_gain  = wr_data[GAIN_W-1:0];
            REG_DERIV_GAIN:  cfg_in.deriv_gain  = wr_data[GAIN_W-1:0];
            REG_DEAD_BAND:   cfg_in.dead_band   = wr_data[LIM_W-1:0];
            REG_INTEG_LIMIT: cfg_in.integ_limit = wr_data[LIM_W-1:0];
            REG_OUT_LIMIT:   cfg_in.out_limit   = wr_data[LIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= RST_PROP_GAIN;
         cfg_ff.integ_gain  <= RST_INTEG_GAIN;
         cfg_ff.deriv_gain  <= RST_DERIV_GAIN;
         cfg_ff.dead_band   <= RST_DEAD_BAND;
         cfg_ff.integ_limit <= RST_INTEG_LIMIT;
         cfg_ff.out_limit   <= RST_OUT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/pidd_core.sv -----
// ----------------------------------------------------------------------------
// pidd_core
// error, p/i/d terms, clamps and controller state for one sample per cycle while step is high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidd_core
   import pidd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     step,
   input  logic signed [DATA_W-1:0] measured,
   input  logic signed [DATA_W-1:0] setpoint,
   output logic signed [DATA_W-1:0] drive
);

   logic signed [ERR_W-1:0]  prev_err_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] held_ff;

   logic signed [ERR_W-1:0]  err;
   logic        [ERR_W-2:0]  mag;
   logic                     active;
   logic signed [DIFF_W-1:0] diff;
   logic signed [P_W-1:0]    p_term;
   logic signed [P_W-1:0]    i_inc;
   logic signed [D_W-1:0]    d_term;
   logic signed [ISUM_W-1:0] ilim;
   logic signed [ISUM_W-1:0] isum;
   logic signed [ISUM_W-1:0] iclamp;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  olim;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  sclamp;
   logic signed [CLIM_W-1:0] sc_b;
   logic signed [DATA_W-1:0] new_drive;

   assign err    = ERR_W'(setpoint) - ERR_W'(measured);
   assign mag    = err[ERR_W-1] ? (ERR_W-1)'(-err) : (ERR_W-1)'(err);
   assign active = mag > (ERR_W-1)'(cfg.dead_band);
   assign diff   = DIFF_W'(err) - DIFF_W'(prev_err_ff);

   assign p_term = $signed({1'b0, cfg.prop_gain}) * err;
   assign i_inc  = $signed({1'b0, cfg.integ_gain}) * err;
   assign d_term = $signed({1'b0, cfg.deriv_gain}) * diff;

   // limits carry the same fraction bits as the terms
   assign ilim = {{(ISUM_W-LIM_W-FRAC_BITS){1'b0}}, cfg.integ_limit, {FRAC_BITS{1'b0}}};
   assign olim = {{(SUM_W-LIM_W-FRAC_BITS){1'b0}}, cfg.out_limit, {FRAC_BITS{1'b0}}};

   assign isum = ISUM_W'(i_inc) + ISUM_W'(acc_ff);

   always_comb begin
      if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = isum;
      end
   end

   assign acc_in = ACC_W'(iclamp);
   assign sum    = SUM_W'(p_term) + SUM_W'(acc_in) + SUM_W'(d_term);

   always_comb begin
      if (sum > olim) begin
         sclamp = olim;
      end else if (sum < -olim) begin
         sclamp = -olim;
      end else begin
         sclamp = sum;
      end
   end

   // truncate toward zero: bias negatives before the shift
   assign sc_b      = CLIM_W'(sclamp) + (sclamp[SUM_W-1] ? TRUNC_BIAS : '0);
   assign new_drive = DATA_W'(sc_b >>> FRAC_BITS);

   assign drive = active ? new_drive : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         acc_ff      <= '0;
         held_ff     <= '0;
      end else if (step) begin
         prev_err_ff <= err;
         if (active) begin
            acc_ff  <= acc_in;
            held_ff <= new_drive;
         end
      end
   end

   `PIDD_ASSERT(a_drive_in_limit, clock, reset,
      step && active |-> (sclamp <= olim) && (sclamp >= -olim))
   `PIDD_ASSERT(a_acc_in_limit, clock, reset,
      step && active |=> (ISUM_W'(acc_ff) <= $past(ilim)) && (ISUM_W'(acc_ff) >= -$past(ilim)))
   `PIDD_ASSERT(a_deadband_holds, clock, reset,
      step && !active |=> $stable(held_ff) && $stable(acc_ff))
   `PIDD_ASSERT(a_idle_keeps_state, clock, reset,
      !step |=> $stable(prev_err_ff) && $stable(acc_ff) && $stable(held_ff))

endmodule

// ----- hdl/pid_controller_deadband.sv -----
// ----------------------------------------------------------------------------
// pid_controller_deadband
// positional pid controller with deadband, integral clamp and output clamp
//
//   port group  dir  tdata fields (low bit up)      word moves when
//   req_*       in   measured[15:0] setpoint[31:16]  req_tvalid & req_tready
//   rsp_*       out  drive[15:0]                     rsp_tvalid & rsp_tready
//   csr_*       in   csr_index, csr_data             csr_valid & csr_ready
//
// one word per cycle while rsp_tready is high; rsp_tvalid rises once an accepted word
// has passed the input register and then, after one pass of the datapath, the result register
// the feedback path is the integral accumulator, previous error and held drive
// reset clears valids, controller state and loads the default gains
// a stalled result stage still lets one more word into the input register
// csr_ready is always high
// ----------------------------------------------------------------------------
module pid_controller_deadband
   import pidd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // measured, setpoint
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // drive
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic signed [DATA_W-1:0] s1_meas_ff;
   logic signed [DATA_W-1:0] s1_setp_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff;
   logic signed [DATA_W-1:0] core_drive;
   logic                     out_free;
   logic                     step;
   logic                     req_fire;

   assign csr_ready = 1'b1;

   pidd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   pidd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .measured (s1_meas_ff),
      .setpoint (s1_setp_ff),
      .drive    (core_drive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meas_ff <= $signed(req_tdata[15:0]);
         s1_setp_ff <= $signed(req_tdata[31:16]);
      end
      if (step) begin
         rsp_drive_ff <= core_drive;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;

endmodule
